/* rtl/cuckoo_string_set_assert.svh */
// Assertion helpers for the cuckoo string set checker.
`ifndef CUCKOO_STRING_SET_ASSERT_SVH
`define CUCKOO_STRING_SET_ASSERT_SVH

// Checked only while out of reset.
`define CSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cuckoo_string_set: assertion failed");

// Checked at every edge, reset included.
`define CSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cuckoo_string_set: assertion failed");

`endif

/* rtl/css_pkg.sv */
package css_pkg;

  localparam int unsigned KEY_W   = 30;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned KICK_W  = 8;

  localparam logic [10:0]       KEY_MULT  = 11'd1153;
  localparam logic [KEY_W-1:0]  KEY_MOD   = 30'd1000000003;
  localparam logic [KEY_W-1:0]  FOLD_BIAS = 30'd999999907;  // KEY_MOD - 96
  localparam logic [31:0]       GOLDEN_Q32 = 32'h9E37_79B9;
  localparam logic [KICK_W-1:0] KICK_RESET = 8'd100;

  // Fold datapath widths: product < 2^41, quotient estimate from top 21 bits.
  localparam int unsigned P_W    = 41;
  localparam int unsigned REC_SH = 20;
  localparam int unsigned REC_W  = 21;
  localparam int unsigned QP_W   = 42;
  localparam int unsigned Q_W    = 12;
  // floor(2^50 / KEY_MOD)
  localparam logic [REC_W-1:0] RECIP = 21'd1125899;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_PRESENT = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_RDA,
    S_RDB,
    S_CHK
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic              start;
    logic              last;
    logic [CHAR_W-1:0] char_code;
  } fold_req_t;

  typedef struct packed {
    logic             done;
    logic             last;
    logic [KEY_W-1:0] key;
  } fold_rsp_t;

endpackage

/* rtl/css_if.sv */
interface css_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, opcode, char_code, last_char, input ready);
  modport sink (input valid, opcode, char_code, last_char, output ready);
endinterface

interface css_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  insert_status;
  logic [29:0] word_key;
  logic [29:0] dropped_key;

  modport source (output valid, found, insert_status, word_key, dropped_key, input ready);
  modport sink (input valid, found, insert_status, word_key, dropped_key, output ready);
endinterface

interface css_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] kick_limit;

  modport source (output valid, kick_limit, input ready);
  modport sink (input valid, kick_limit, output ready);
endinterface

/* rtl/cuckoo_string_set.sv */
// Cuckoo-hashed set of lowercase words.
// in_i carries one character per item (opcode, char_code, last_char); the
// characters fold into a rolling key modulo 1000000003. The item with
// last_char set runs the opcode (insert or search) on the finished key and
// yields one item on out_o; other characters yield nothing.
// cfg_i writes kick_limit (reset 100) and is always ready; write it only
// while the block is idle.
// Each accepted character runs through three steps in the fold unit
// (multiply, reciprocal quotient, multiply-subtract; the final correction is
// combinational on the way back into the rolling key); in_i is not ready
// again until the fold is done. After the fold of the last character the
// word passes through S_RDA (hash, first read), S_RDB (second read of
// the single-read-port slot memory) and S_CHK, where the result enters
// the output register once it is free; each eviction round repeats them.
// After reset the block sweeps the slot memory clear, one slot per cycle,
// through all TABLE_DEPTH slots with in_i not ready.
// The result waits in an output register; a stalled out_o does not block new
// characters, only the finish of the next word while the register is full.
// TABLE_DEPTH must be a power of two.
module cuckoo_string_set
  import css_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input logic         clk_i,
  input logic         rst_ni,
  css_in_if.sink      in_i,
  css_out_if.source   out_o,
  css_cfg_if.sink     cfg_i
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SLOT_W = $bits(slot_t);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [KICK_W-1:0] kick_q;
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  cur_q;
  logic [KICK_W-1:0] rounds_q;
  logic              first_q;
  slot_t             ea_q;

  logic              out_valid_q;
  logic              out_found_q;
  status_e           out_status_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [KEY_W-1:0]  out_drop_q;

  fold_req_t         fold_req;
  fold_rsp_t         fold_rsp;
  logic              in_acc;

  logic [ADDR_W-1:0] idx_a, idx_b;
  logic              hash_en;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             eb;

  logic              hit, can_load, load;
  logic              chk_done, chk_kick, wr_a, wr_b;
  logic              res_found;
  status_e           res_status;
  logic [KEY_W-1:0]  res_drop;

  assign in_acc = in_i.valid && in_i.ready;

  assign fold_req.start     = in_acc;
  assign fold_req.last      = in_i.last_char;
  assign fold_req.char_code = in_i.char_code;

  css_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fold_req),
    .rsp_o  (fold_rsp)
  );

  assign idx_a = cur_q[ADDR_W-1:0];

  css_slot_hash #(.ADDR_W(ADDR_W)) u_hash (
    .clk_i (clk_i),
    .en_i  (hash_en),
    .key_i (cur_q),
    .idx_o (idx_b)
  );

  css_slot_ram #(.ADDR_W(ADDR_W), .DATA_W(SLOT_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eb       = slot_t'(ram_rdata);
  assign hit      = (ea_q.valid && ea_q.key == cur_q) || (eb.valid && eb.key == cur_q);
  assign can_load = !out_valid_q || out_o.ready;

  // decision on the two candidate slots of the key in hand
  always_comb begin
    chk_done   = 1'b0;
    chk_kick   = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    res_found  = 1'b0;
    res_status = ST_PLACED;
    res_drop   = '0;
    if (op_q == OP_SEARCH) begin
      chk_done  = 1'b1;
      res_found = hit;
    end else if (hit) begin
      // a displaced key that is already home is simply discarded
      chk_done   = 1'b1;
      res_status = first_q ? ST_PRESENT : ST_PLACED;
    end else if (!ea_q.valid) begin
      chk_done = 1'b1;
      wr_a     = 1'b1;
    end else if (!eb.valid) begin
      chk_done = 1'b1;
      wr_b     = 1'b1;
    end else if (rounds_q == '0) begin
      chk_done   = 1'b1;
      res_status = ST_DROPPED;
      res_drop   = cur_q;
    end else begin
      chk_kick = 1'b1;
      wr_a     = 1'b1;
    end
  end

  assign clr_addr_d = clr_addr_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (&clr_addr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if (fold_rsp.done) begin
          state_d = fold_rsp.last ? S_RDA : S_IDLE;
        end
      end
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = S_CHK;
      S_CHK: begin
        if (chk_kick) begin
          state_d = S_RDA;
        end else if (chk_done && can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    hash_en    = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_a;
    ram_we     = 1'b0;
    ram_waddr  = idx_a;
    ram_wdata  = '{valid: 1'b1, key: cur_q};
    load       = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      S_IDLE: in_i.ready = 1'b1;
      S_FOLD: ;
      S_RDA: begin
        hash_en = 1'b1;
        ram_re  = 1'b1;
      end
      S_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = idx_b;
      end
      S_CHK: begin
        load      = chk_done && can_load;
        ram_we    = (wr_a || wr_b) && (chk_kick || can_load);
        ram_waddr = wr_b ? idx_b : idx_a;
      end
      default: ;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      kick_q      <= KICK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_d;
      end
      if (cfg_i.valid) begin
        kick_q <= cfg_i.kick_limit;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_e'(in_i.opcode);
    end
    if (state_q == S_FOLD && fold_rsp.done && fold_rsp.last) begin
      key_q    <= fold_rsp.key;
      cur_q    <= fold_rsp.key;
      rounds_q <= kick_q;
      first_q  <= 1'b1;
    end
    if (state_q == S_RDB) begin
      ea_q <= slot_t'(ram_rdata);
    end
    if (state_q == S_CHK && chk_kick) begin
      cur_q    <= ea_q.key;
      rounds_q <= rounds_q - 1'b1;
      first_q  <= 1'b0;
    end
    if (load) begin
      out_found_q  <= res_found;
      out_status_q <= res_status;
      out_key_q    <= key_q;
      out_drop_q   <= res_drop;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = out_found_q;
  assign out_o.insert_status = out_status_q;
  assign out_o.word_key      = out_key_q;
  assign out_o.dropped_key   = out_drop_q;

endmodule

/* rtl/css_fold.sv */
module css_fold
  import css_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fold_req_t req_i,
  output fold_rsp_t rsp_o
);

  logic [KEY_W-1:0] rk_q, rk_d;
  logic [2:0]       vld_q;
  logic             last_q;
  logic [P_W-1:0]   p_q, p_d;
  logic [Q_W-1:0]   q_q, q_d;
  logic [KEY_W:0]   r_q, r_d;
  logic [QP_W-1:0]  qprod;
  logic [QP_W-1:0]  diff;
  logic [KEY_W:0]   r_sub;
  logic [KEY_W-1:0] key;

  // rk*1153 + c - 96, kept non-negative by adding KEY_MOD
  assign p_d = P_W'(rk_q) * P_W'(KEY_MULT) + P_W'(req_i.char_code) + P_W'(FOLD_BIAS);

  // quotient estimate is exact or one low
  assign qprod = QP_W'(p_q[P_W-1:REC_SH]) * QP_W'(RECIP);
  assign q_d   = qprod[QP_W-1:QP_W-Q_W];

  assign diff = QP_W'(p_q) - QP_W'(q_q) * QP_W'(KEY_MOD);
  assign r_d  = diff[KEY_W:0];

  assign r_sub = r_q - {1'b0, KEY_MOD};
  assign key   = (r_q >= {1'b0, KEY_MOD}) ? r_sub[KEY_W-1:0] : r_q[KEY_W-1:0];
  assign rk_d  = last_q ? '0 : key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rk_q   <= '0;
      last_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.start};
      if (req_i.start) begin
        last_q <= req_i.last;
      end
      if (vld_q[2]) begin
        rk_q <= rk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q <= p_d;
    end
    if (vld_q[0]) begin
      q_q <= q_d;
    end
    if (vld_q[1]) begin
      r_q <= r_d;
    end
  end

  assign rsp_o.done = vld_q[2];
  assign rsp_o.last = last_q;
  assign rsp_o.key  = key;

endmodule

/* rtl/css_slot_hash.sv */
module css_slot_hash
  import css_pkg::*;
#(
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic [ADDR_W-1:0] idx_o
);

  logic [KEY_W+31:0] prod;
  logic [31:0]       frac_q;

  // frac(key * golden ratio) in Q0.32; slot is its top bits
  assign prod = (KEY_W+32)'(key_i) * (KEY_W+32)'(GOLDEN_Q32);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac_q <= prod[31:0];
    end
  end

  assign idx_o = frac_q[31 -: ADDR_W];

endmodule

/* rtl/css_slot_ram.sv */
module css_slot_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 31
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/css_checker.sv */
`include "cuckoo_string_set_assert.svh"

module css_checker
  import css_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             found_i,
  input logic [1:0]       insert_status_i,
  input logic [KEY_W-1:0] dropped_key_i
);

  // a stalled result stays offered
  `CSS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // found only comes from a search, which reports insert status ST_PLACED and no dropped key
  `CSS_ASSERT(a_found_search, clk_i, rst_ni,
              out_valid_i && found_i |-> insert_status_i == ST_PLACED && dropped_key_i == '0)

  `CSS_ASSERT(a_drop_zero, clk_i, rst_ni,
              out_valid_i && insert_status_i != ST_DROPPED |-> dropped_key_i == '0)

  // the fold is registered, so no result right after an accepted item
  `CSS_ASSERT(a_min_latency, clk_i, rst_ni,
              $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))

  `CSS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i && !in_ready_i)

endmodule

bind cuckoo_string_set css_checker u_css_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .found_i         (out_o.found),
  .insert_status_i (out_o.insert_status),
  .dropped_key_i   (out_o.dropped_key)
);
